// ===== hdl/bsc_pkg.sv =====
// bsc_pkg: shared widths, beat payload types and saturation helpers for the
// box-sphere contact geometry pipeline. No dependencies.
package bsc_pkg;

  // field formats
  localparam int CB   = 20;            // length width (Q9.10)
  localparam int UB   = 16;            // unit value width (Q1.14)
  localparam int UF   = UB - 2;        // unit fraction bits

  // internal widths
  localparam int RI   = 35;            // rotation entry before rounding
  localparam int RW   = 20;            // rotation entry
  localparam int RELW = CB + 1;        // centre offset
  localparam int LOCW = CB + 1;        // clamped local coordinate
  localparam int PW   = RW + RELW;     // rotation product
  localparam int AW   = PW + 2;        // three-term sum
  localparam int CBW  = 28;            // clamped point in world frame
  localparam int VW   = 29;            // vector to normalize
  localparam int SQW  = 2 * VW;        // sum of squares
  localparam int LENW = VW;            // vector length
  localparam int SQ_STEPS = SQW / 2;   // root bits, one per stage
  localparam int QB   = 16;            // quotient bits
  localparam int MW   = 46;            // dividend width
  localparam int DW   = LENW + 1;      // divisor width
  localparam int NW   = QB + 1;        // signed normal component
  localparam int LW   = CB + 2;        // multiplier length operand
  localparam int PRW  = NW + LW;       // back end product
  localparam int DEPW = LENW + 2;      // unsaturated depth

  typedef struct packed {
    logic [3*CB-1:0] box_position;
    logic [4*UB-1:0] box_orientation;
    logic [3*CB-1:0] box_extents;
    logic [3*CB-1:0] sphere_position;
    logic [CB-2:0]   sphere_radius;
    logic            keep_if_apart;
    logic            pair_is_real;
    logic            has_previous;
    logic [3*UB-1:0] previous_normal;
  } in_t;

  typedef struct packed {
    logic                   contact_kept;
    logic                   centre_inside;
    logic [3*CB-1:0]        contact_point;
    logic [3*UB-1:0]        contact_normal;
    logic [3*UB-1:0]        prior_normal_out;
    logic signed [CB-1:0]   penetration_depth;
  } out_t;

  // per-pair data that rides along the whole pipe
  typedef struct packed {
    logic [2:0][CB-1:0] sp;
    logic [CB-2:0]      r;
    logic               keep_if_apart;
    logic               pair_is_real;
    logic               has_previous;
    logic [3*UB-1:0]    prev;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic               in_box;
    logic [CB-1:0]      clear;
    logic [2:0][VW-1:0] p1;
    logic [2:0][VW-1:0] vec;
  } geo_t;

  typedef struct packed {
    geo_t           geo;
    logic [SQW-1:0] sumsq;
  } fr_t;

  typedef struct packed {
    geo_t            geo;
    logic [LENW-1:0] len;
  } rt_t;

  typedef struct packed {
    geo_t               geo;
    logic [LENW-1:0]    len;
    logic [2:0][QB-1:0] quot;
    logic [2:0]         neg;
    logic               zero;
  } nm_t;

  function automatic logic [CB-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'((1 << (CB - 1)) - 1);
    lo = -hi - 32'sd1;
    if (v > hi) sat_coord = hi[CB-1:0];
    else if (v < lo) sat_coord = lo[CB-1:0];
    else sat_coord = v[CB-1:0];
  endfunction

  function automatic logic [UB-1:0] sat_unit(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'((1 << (UB - 1)) - 1);
    lo = -hi - 32'sd1;
    if (v > hi) sat_unit = hi[UB-1:0];
    else if (v < lo) sat_unit = lo[UB-1:0];
    else sat_unit = v[UB-1:0];
  endfunction

endpackage

// ===== hdl/bsc_front.sv =====
// bsc_front: eight-stage front end, quaternion to rotation, box-frame clamp,
// face pick or clamped offset, sum of squares. Depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output fr_t  out_data_o
);

  localparam int NST = 8;
  localparam logic signed [RI-1:0] ONE2   = RI'(1) <<< (2 * UF);
  localparam logic signed [RI-1:0] HALF_R = RI'(1) <<< (UF - 1);
  localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (UF - 1);

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_q[i] || rdy[i+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 1: unpack, offset, quaternion products
  side_t                 side1_d, side1_q;
  logic signed [CB-1:0]  bp1_d [3], bp1_q [3];
  logic [CB-1:0]         ex1_d [3], ex1_q [3];
  logic signed [RELW-1:0] rel1_d [3], rel1_q [3];
  logic signed [UB-1:0]  qw, qx, qy, qz;
  logic signed [2*UB-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pwx_q, pwy_q, pwz_q;

  always_comb begin
    side1_d.sp            = in_data_i.sphere_position;
    side1_d.r             = in_data_i.sphere_radius;
    side1_d.keep_if_apart = in_data_i.keep_if_apart;
    side1_d.pair_is_real  = in_data_i.pair_is_real;
    side1_d.has_previous  = in_data_i.has_previous;
    side1_d.prev          = in_data_i.previous_normal;
    for (int i = 0; i < 3; i++) begin
      bp1_d[i]  = $signed(in_data_i.box_position[i*CB +: CB]);
      ex1_d[i]  = in_data_i.box_extents[i*CB +: CB];
      rel1_d[i] = RELW'($signed(in_data_i.sphere_position[i*CB +: CB])) - RELW'(bp1_d[i]);
    end
    qw = $signed(in_data_i.box_orientation[0*UB +: UB]);
    qx = $signed(in_data_i.box_orientation[1*UB +: UB]);
    qy = $signed(in_data_i.box_orientation[2*UB +: UB]);
    qz = $signed(in_data_i.box_orientation[3*UB +: UB]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side1_q <= side1_d;
      bp1_q   <= bp1_d;
      ex1_q   <= ex1_d;
      rel1_q  <= rel1_d;
      pxx_q   <= qx * qx;
      pyy_q   <= qy * qy;
      pzz_q   <= qz * qz;
      pxy_q   <= qx * qy;
      pxz_q   <= qx * qz;
      pyz_q   <= qy * qz;
      pwx_q   <= qw * qx;
      pwy_q   <= qw * qy;
      pwz_q   <= qw * qz;
    end
  end

  // stage 2: rotation matrix, rounded
  logic signed [RI-1:0] rt [3][3];
  logic signed [RW-1:0] r2_d [3][3], r2_q [3][3];
  side_t                 side2_q;
  logic signed [CB-1:0]  bp2_q [3];
  logic [CB-1:0]         ex2_q [3];
  logic signed [RELW-1:0] rel2_q [3];

  always_comb begin
    rt[0][0] = ONE2 - ((RI'(pyy_q) + RI'(pzz_q)) <<< 1);
    rt[0][1] = (RI'(pxy_q) - RI'(pwz_q)) <<< 1;
    rt[0][2] = (RI'(pxz_q) + RI'(pwy_q)) <<< 1;
    rt[1][0] = (RI'(pxy_q) + RI'(pwz_q)) <<< 1;
    rt[1][1] = ONE2 - ((RI'(pxx_q) + RI'(pzz_q)) <<< 1);
    rt[1][2] = (RI'(pyz_q) - RI'(pwx_q)) <<< 1;
    rt[2][0] = (RI'(pxz_q) - RI'(pwy_q)) <<< 1;
    rt[2][1] = (RI'(pyz_q) + RI'(pwx_q)) <<< 1;
    rt[2][2] = ONE2 - ((RI'(pxx_q) + RI'(pyy_q)) <<< 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) r2_d[i][j] = RW'((rt[i][j] + HALF_R) >>> UF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      r2_q    <= r2_d;
      side2_q <= side1_q;
      bp2_q   <= bp1_q;
      ex2_q   <= ex1_q;
      rel2_q  <= rel1_q;
    end
  end

  // stage 3: transpose times offset, products
  logic signed [PW-1:0]  m3_d [3][3], m3_q [3][3];
  logic signed [RW-1:0]  r3_q [3][3];
  side_t                 side3_q;
  logic signed [CB-1:0]  bp3_q [3];
  logic [CB-1:0]         ex3_q [3];
  logic signed [RELW-1:0] rel3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m3_d[i][j] = PW'(r2_q[j][i]) * PW'(rel2_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      m3_q    <= m3_d;
      r3_q    <= r2_q;
      side3_q <= side2_q;
      bp3_q   <= bp2_q;
      ex3_q   <= ex2_q;
      rel3_q  <= rel2_q;
    end
  end

  // stage 4: local coordinates, clamp to the box
  logic signed [AW-1:0]   acc4, sh4, exw4;
  logic signed [LOCW-1:0] loc4_d [3], loc4_q [3];
  logic                   in4_d, in4_q;
  logic signed [RW-1:0]   r4_q [3][3];
  side_t                  side4_q;
  logic signed [CB-1:0]   bp4_q [3];
  logic [CB-1:0]          ex4_q [3];
  logic signed [RELW-1:0] rel4_q [3];

  always_comb begin
    in4_d = 1'b1;
    acc4  = '0;
    sh4   = '0;
    exw4  = '0;
    for (int i = 0; i < 3; i++) begin
      acc4 = AW'(m3_q[i][0]) + AW'(m3_q[i][1]) + AW'(m3_q[i][2]);
      sh4  = (acc4 + HALF_A) >>> UF;
      exw4 = $signed(AW'(ex3_q[i]));
      if (sh4 < -exw4) begin
        loc4_d[i] = -$signed(LOCW'(ex3_q[i]));
        in4_d     = 1'b0;
      end else if (sh4 > exw4) begin
        loc4_d[i] = $signed(LOCW'(ex3_q[i]));
        in4_d     = 1'b0;
      end else begin
        loc4_d[i] = LOCW'(sh4);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      loc4_q  <= loc4_d;
      in4_q   <= in4_d;
      r4_q    <= r3_q;
      side4_q <= side3_q;
      bp4_q   <= bp3_q;
      ex4_q   <= ex3_q;
      rel4_q  <= rel3_q;
    end
  end

  // stage 5: face of least clearance, and products for the clamped point
  logic [CB-1:0]          clr5 [3];
  logic signed [LOCW-1:0] al5;
  logic [1:0]             k5;
  logic [CB-1:0]          cmin5;
  logic signed [LOCW-1:0] lk5;
  logic signed [VW-1:0]   col5 [3];
  logic [CB-1:0]          clr5_q;
  logic signed [VW-1:0]   v5_d [3], v5_q [3];
  logic signed [PW-1:0]   m5_d [3][3], m5_q [3][3];
  logic                   in5_q;
  side_t                  side5_q;
  logic signed [CB-1:0]   bp5_q [3];
  logic signed [RELW-1:0] rel5_q [3];

  always_comb begin
    al5 = '0;
    for (int i = 0; i < 3; i++) begin
      al5     = (loc4_q[i] < 0) ? -loc4_q[i] : loc4_q[i];
      clr5[i] = ex4_q[i] - al5[CB-1:0];
    end
    // lowest axis wins a tie
    k5    = 2'd0;
    cmin5 = clr5[0];
    if (clr5[1] < cmin5) begin
      k5    = 2'd1;
      cmin5 = clr5[1];
    end
    if (clr5[2] < cmin5) begin
      k5    = 2'd2;
      cmin5 = clr5[2];
    end
    case (k5)
      2'd1: begin
        lk5 = loc4_q[1];
        for (int j = 0; j < 3; j++) col5[j] = VW'(r4_q[j][1]);
      end
      2'd2: begin
        lk5 = loc4_q[2];
        for (int j = 0; j < 3; j++) col5[j] = VW'(r4_q[j][2]);
      end
      default: begin
        lk5 = loc4_q[0];
        for (int j = 0; j < 3; j++) col5[j] = VW'(r4_q[j][0]);
      end
    endcase
    for (int j = 0; j < 3; j++) begin
      v5_d[j] = (lk5 > 0) ? col5[j] : -col5[j];
      for (int i = 0; i < 3; i++) m5_d[j][i] = PW'(r4_q[j][i]) * PW'(loc4_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      clr5_q  <= cmin5;
      v5_q    <= v5_d;
      m5_q    <= m5_d;
      in5_q   <= in4_q;
      side5_q <= side4_q;
      bp5_q   <= bp4_q;
      rel5_q  <= rel4_q;
    end
  end

  // stage 6: clamped point in world frame, vector to normalize
  logic signed [AW-1:0]  acc6, sh6;
  logic signed [CBW-1:0] cb6;
  logic signed [VW-1:0]  cs6;
  geo_t                  geo6_d, geo6_q;

  always_comb begin
    geo6_d.side   = side5_q;
    geo6_d.in_box = in5_q;
    geo6_d.clear  = clr5_q;
    acc6 = '0;
    sh6  = '0;
    cb6  = '0;
    cs6  = '0;
    for (int j = 0; j < 3; j++) begin
      acc6 = AW'(m5_q[j][0]) + AW'(m5_q[j][1]) + AW'(m5_q[j][2]);
      sh6  = (acc6 + HALF_A) >>> UF;
      cb6  = CBW'(sh6);
      cs6  = VW'(cb6) - VW'(rel5_q[j]);
      geo6_d.p1[j]  = VW'(bp5_q[j]) + VW'(cb6);
      geo6_d.vec[j] = in5_q ? v5_q[j] : cs6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) geo6_q <= geo6_d;
  end

  // stage 7: squares
  logic [SQW-1:0] sq7_q [3];
  geo_t           geo7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int j = 0; j < 3; j++) begin
        sq7_q[j] <= SQW'($signed(geo6_q.vec[j]) * $signed(geo6_q.vec[j]));
      end
      geo7_q <= geo6_q;
    end
  end

  // stage 8: sum of squares
  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      out_data_o.geo   <= geo7_q;
      out_data_o.sumsq <= sq7_q[0] + sq7_q[1] + sq7_q[2];
    end
  end

endmodule

// ===== hdl/bsc_sqrt.sv =====
// bsc_sqrt: pipelined floor square root of the sum of squares, one root bit
// per stage. Depends on bsc_pkg.
module bsc_sqrt import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  fr_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rt_t  out_data_o
);

  localparam int NST = SQ_STEPS;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_q[i] || rdy[i+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  geo_t           geo_q  [NST];
  logic [SQW-1:0] root_q [NST];
  logic [SQW-1:0] rem_q  [NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_step
    localparam logic [SQW:0] BIT = (SQW + 1)'(1) << (2 * (NST - 1 - k));
    logic [SQW-1:0] rem_in, root_in, rem_nx, root_nx;
    logic [SQW:0]   trial;
    geo_t           geo_in;

    if (k == 0) begin : g_first
      assign rem_in  = in_data_i.sumsq;
      assign root_in = '0;
      assign geo_in  = in_data_i.geo;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign geo_in  = geo_q[k-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + BIT;
      if ({1'b0, rem_in} >= trial) begin
        rem_nx  = rem_in - trial[SQW-1:0];
        root_nx = (root_in >> 1) + BIT[SQW-1:0];
      end else begin
        rem_nx  = rem_in;
        root_nx = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        root_q[k] <= root_nx;
        geo_q[k]  <= geo_in;
      end
    end

    if (k < NST - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (rdy[k]) rem_q[k] <= rem_nx;
      end
    end
  end

  assign out_data_o.geo = geo_q[NST-1];
  assign out_data_o.len = root_q[NST-1][LENW-1:0];

endmodule

// ===== hdl/bsc_norm.sv =====
// bsc_norm: three pipelined restoring dividers that scale the vector by its
// length, one quotient bit per stage after a setup stage. Depends on bsc_pkg.
module bsc_norm import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rt_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output nm_t  out_data_o
);

  localparam int NST = QB + 1;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_q[i] || rdy[i+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  nm_t           nm_q [NST];
  logic [MW-1:0] m_q  [NST-1][3];
  logic [DW-1:0] d_q  [NST-1];

  // setup: round-to-nearest numerator, floor division on magnitudes
  nm_t                  nm0_d;
  logic [DW-1:0]        d0_d;
  logic [MW-1:0]        m0_d [3];
  logic signed [MW-1:0] nn0;

  always_comb begin
    nm0_d.geo  = in_data_i.geo;
    nm0_d.len  = in_data_i.len;
    nm0_d.quot = '0;
    nm0_d.zero = (in_data_i.len == '0);
    d0_d       = {in_data_i.len, 1'b0};
    nn0        = '0;
    for (int j = 0; j < 3; j++) begin
      nn0 = (MW'($signed(in_data_i.geo.vec[j])) <<< (UF + 1)) + $signed(MW'(in_data_i.len));
      nm0_d.neg[j] = nn0[MW-1];
      m0_d[j] = nn0[MW-1] ? MW'(-nn0 + $signed(MW'(d0_d)) - MW'(1)) : MW'(nn0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      nm_q[0] <= nm0_d;
      d_q[0]  <= d0_d;
      m_q[0]  <= m0_d;
    end
  end

  for (genvar s = 1; s < NST; s++) begin : g_div
    localparam int BI = QB - s;
    nm_t           nm_nx;
    logic [MW-1:0] m_nx [3];
    logic [MW-1:0] dsh;

    always_comb begin
      nm_nx = nm_q[s-1];
      dsh   = MW'(d_q[s-1]) << BI;
      for (int j = 0; j < 3; j++) begin
        if (m_q[s-1][j] >= dsh) begin
          m_nx[j]          = m_q[s-1][j] - dsh;
          nm_nx.quot[j][BI] = 1'b1;
        end else begin
          m_nx[j] = m_q[s-1][j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) nm_q[s] <= nm_nx;
    end

    if (s < NST - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (rdy[s]) begin
          m_q[s] <= m_nx;
          d_q[s] <= d_q[s-1];
        end
      end
    end
  end

  assign out_data_o = nm_q[NST-1];

endmodule

// ===== hdl/bsc_back.sv =====
// bsc_back: two-stage back end, surface offsets, depth, keep decision and
// the output register. Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  nm_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int NST = 2;
  localparam logic signed [PRW-1:0] HALF_IN  = PRW'(1) <<< UF;
  localparam logic signed [PRW-1:0] HALF_OUT = PRW'(1) <<< (UF - 1);

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_q[i] || rdy[i+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // stage 1: signed normal, one product per lane, raw depth
  logic signed [NW-1:0]   n1_d [3], n1_q [3];
  logic signed [LW-1:0]   lim1;
  logic signed [PRW-1:0]  pr1_d [3], pr1_q [3];
  logic signed [DEPW-1:0] dep1_d, dep1_q;
  geo_t                   geo1_q;

  always_comb begin
    if (in_data_i.geo.in_box) begin
      lim1   = $signed(LW'(in_data_i.geo.clear)) - $signed(LW'(in_data_i.geo.side.r));
      dep1_d = $signed(DEPW'(in_data_i.geo.clear)) + $signed(DEPW'(in_data_i.geo.side.r));
    end else begin
      lim1   = $signed(LW'(in_data_i.geo.side.r));
      dep1_d = $signed(DEPW'(in_data_i.geo.side.r)) - $signed(DEPW'(in_data_i.len));
    end
    for (int j = 0; j < 3; j++) begin
      if (in_data_i.zero) n1_d[j] = '0;
      else if (in_data_i.neg[j]) n1_d[j] = -$signed({1'b0, in_data_i.quot[j]});
      else n1_d[j] = $signed({1'b0, in_data_i.quot[j]});
      pr1_d[j] = PRW'(n1_d[j]) * PRW'(lim1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      n1_q   <= n1_d;
      pr1_q  <= pr1_d;
      dep1_q <= dep1_d;
      geo1_q <= in_data_i.geo;
    end
  end

  // stage 2: contact point, saturation, keep decision
  logic signed [PRW-1:0] t2;
  logic signed [31:0]    sp2, p2, s2, pt2;
  logic signed [NW-1:0]  nv2;
  logic [3*CB-1:0]       cp2;
  logic [3*UB-1:0]       np2;
  logic                  kept2;
  out_t                  out_d, out_q;

  always_comb begin
    t2  = '0;
    sp2 = '0;
    p2  = '0;
    s2  = '0;
    pt2 = '0;
    nv2 = '0;
    for (int j = 0; j < 3; j++) begin
      sp2 = 32'($signed(geo1_q.side.sp[j]));
      if (geo1_q.in_box) begin
        t2  = (pr1_q[j] + HALF_IN) >>> (UF + 1);
        pt2 = sp2 + 32'(t2);
        nv2 = n1_q[j];
      end else begin
        // midpoint of box surface point and sphere surface point
        t2  = (pr1_q[j] + HALF_OUT) >>> UF;
        p2  = sp2 + 32'(t2);
        s2  = 32'($signed(geo1_q.p1[j])) + p2;
        pt2 = (s2 + 32'sd1) >>> 1;
        nv2 = -n1_q[j];
      end
      cp2[j*CB +: CB] = sat_coord(pt2);
      np2[j*UB +: UB] = sat_unit(32'(nv2));
    end
    kept2 = geo1_q.in_box || !dep1_q[DEPW-1] || geo1_q.side.pair_is_real ||
            geo1_q.side.keep_if_apart;
    out_d = '0;
    out_d.centre_inside = geo1_q.in_box;
    if (kept2) begin
      out_d.contact_kept      = 1'b1;
      out_d.contact_point     = cp2;
      out_d.contact_normal    = np2;
      out_d.prior_normal_out  = geo1_q.side.has_previous ? geo1_q.side.prev : np2;
      out_d.penetration_depth = $signed(sat_coord(32'(dep1_q)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/box_sphere_contact_geometry.sv =====
// box_sphere_contact_geometry: oriented box against sphere contact geometry.
// Front end, square root (one root bit per stage), dividers (setup and one
// quotient bit per stage), back end. One pair per cycle unless stalled;
// every stage stalls on its own, so bubbles close up behind a stalled
// output. Reset clears all stage valid bits only.
module box_sphere_contact_geometry import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic fr_valid, fr_ready, rt_valid, rt_ready, nm_valid, nm_ready;
  fr_t  fr_data;
  rt_t  rt_data;
  nm_t  nm_data;

  bsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  bsc_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_data_o  (rt_data)
  );

  bsc_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_data_i   (rt_data),
    .out_valid_o (nm_valid),
    .out_ready_i (nm_ready),
    .out_data_o  (nm_data)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nm_valid),
    .in_ready_o  (nm_ready),
    .in_data_i   (nm_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // input only backs up when the whole pipe is full behind a stalled beat
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the pipe has room");

  a_inside_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.centre_inside) |->
      (out_data_o.contact_kept && !out_data_o.penetration_depth[CB-1]))
    else $error("inside contact dropped or with negative depth");

  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.contact_kept) |->
      (out_data_o.penetration_depth == '0 && out_data_o.contact_normal == '0 &&
       out_data_o.contact_point == '0))
    else $error("dropped contact carries geometry");

endmodule
